// ----- rtl/core/bidirectional_byte_stack_unit_macros.svh -----
// Assertion macros shared by the checker files of the byte stack unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BIDIRECTIONAL_BYTE_STACK_UNIT_MACROS_SVH
`define BIDIRECTIONAL_BYTE_STACK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bbs_pkg.sv -----
package bbs_pkg;

    // Number of bytes in the stack store.
    localparam int STACK_DEPTH = 256;
    localparam int PTR_W = $clog2(STACK_DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_DUP     = 3'd2,
        CMD_DROP    = 3'd3,
        CMD_PEEK    = 3'd4,
        CMD_COMPARE = 3'd5
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Step the pointer up by one, wrapping at the end of the store.
    function automatic ptr_t ptr_inc(ptr_t p);
        if (p == ptr_t'(STACK_DEPTH - 1)) begin
            return '0;
        end
        return p + ptr_t'(1);
    endfunction

    // Step the pointer down by one, wrapping at the start of the store.
    function automatic ptr_t ptr_dec(ptr_t p);
        if (p == '0) begin
            return ptr_t'(STACK_DEPTH - 1);
        end
        return p - ptr_t'(1);
    endfunction

    // One step in the direction of growth.
    function automatic ptr_t ptr_grow(ptr_t p, logic down);
        return down ? ptr_dec(p) : ptr_inc(p);
    endfunction

    // One step against the direction of growth.
    function automatic ptr_t ptr_shrink(ptr_t p, logic down);
        return down ? ptr_inc(p) : ptr_dec(p);
    endfunction

endpackage

// ----- rtl/core/bidirectional_byte_stack_unit.sv -----
// Channel | valid     | stall     | fields
// input   | in_valid  | in_stall  | command, grow_down, push_value
// output  | out_valid | out_stall | read_value, zero_out, carry_out, pointer_out
//
// An item is handled in order: the top and second entries are read from the
// two memory copies as it is taken, then the result is computed and written back.
// The next item is taken only after the write-back, so no forwarding is needed.
// A stalled result holds the unit in its compute cycle; the read data holds too.
// Reset clears the pointer, flags and a valid bit per entry at once; an entry
// without its valid bit reads as zero, so there is no clearing pass.
module bidirectional_byte_stack_unit
    import bbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic       grow_down,
    input  logic [7:0] push_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_value,
    output logic       zero_out,
    output logic       carry_out,
    output logic [7:0] pointer_out
);

    state_t                 state_reg, state_next;
    ptr_t                   sp_reg, sp_next;
    logic                   zero_reg, zero_next;
    logic                   carry_reg, carry_next;
    logic [STACK_DEPTH-1:0] valid_reg;

    // Item captured at the input transfer.
    cmd_t  cmd_reg;
    logic  down_reg;
    byte_t val_reg;
    ptr_t  a_addr_reg;
    logic  a_vld_reg;
    logic  b_vld_reg;

    logic  out_valid_reg, out_valid_next;
    byte_t read_value_reg, read_value_next;
    logic  zero_out_reg;
    logic  carry_out_reg;
    ptr_t  pointer_out_reg;

    logic  accept;
    logic  done;
    ptr_t  a_addr_in, b_addr_in;
    byte_t a_data, b_data, a_val, b_val;
    logic  wr_en;
    byte_t wr_data;
    logic  clr_vld;

    // Neighbor addresses of the incoming item.
    assign a_addr_in = ptr_shrink(sp_reg, grow_down);
    assign b_addr_in = ptr_shrink(a_addr_in, grow_down);

    // Two copies of the store give two read ports.
    bbs_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sp_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (a_addr_in),
        .rd_data (a_data)
    );

    bbs_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sp_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (b_addr_in),
        .rd_data (b_data)
    );

    // Entries never written since reset read as zero.
    assign a_val = a_vld_reg ? a_data : 8'd0;
    assign b_val = b_vld_reg ? b_data : 8'd0;

    // Sequencer, command execution and output register load.
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        zero_next       = zero_reg;
        carry_next      = carry_reg;
        read_value_next = 8'd0;
        wr_en           = 1'b0;
        wr_data         = val_reg;
        clr_vld         = 1'b0;
        in_stall        = 1'b1;
        accept          = 1'b0;
        done            = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done = !out_valid_reg || !out_stall;
                if (done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            wr_en   = 1'b1;
                            wr_data = val_reg;
                            sp_next = ptr_grow(sp_reg, down_reg);
                        end
                        CMD_POP:
                        begin
                            read_value_next = a_val;
                            clr_vld         = 1'b1;
                            sp_next         = a_addr_reg;
                        end
                        CMD_DUP:
                        begin
                            wr_en   = 1'b1;
                            wr_data = a_val;
                            sp_next = ptr_grow(sp_reg, down_reg);
                        end
                        CMD_DROP:
                        begin
                            clr_vld = 1'b1;
                            sp_next = a_addr_reg;
                        end
                        CMD_PEEK:
                        begin
                            read_value_next = a_val;
                        end
                        CMD_COMPARE:
                        begin
                            zero_next  = (a_val == b_val);
                            carry_next = (a_val < b_val);
                        end
                        default:
                        begin
                            read_value_next = 8'd0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, pointer, flags and entry valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            zero_reg      <= 1'b0;
            carry_reg     <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            zero_reg      <= zero_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                valid_reg[sp_reg] <= 1'b1;
            end
            if (clr_vld)
            begin
                valid_reg[a_addr_reg] <= 1'b0;
            end
        end
    end

    // Item capture at the input transfer and result payload at completion.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            down_reg   <= grow_down;
            val_reg    <= push_value;
            a_addr_reg <= a_addr_in;
            a_vld_reg  <= valid_reg[a_addr_in];
            b_vld_reg  <= valid_reg[b_addr_in];
        end
        if (done)
        begin
            read_value_reg  <= read_value_next;
            zero_out_reg    <= zero_next;
            carry_out_reg   <= carry_next;
            pointer_out_reg <= sp_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign zero_out    = zero_out_reg;
    assign carry_out   = carry_out_reg;
    assign pointer_out = 8'(pointer_out_reg);

endmodule

// ----- rtl/core/bbs_ram.sv -----
module bbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port and a registered read port that holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bbs_checker.sv -----
`include "bidirectional_byte_stack_unit_macros.svh"

module bbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       zero_out,
    input logic       carry_out,
    input logic [7:0] pointer_out
);

    // A waiting result stays offered until its transfer.
    `BBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")

    // A stalled result keeps its pointer.
    `BBS_ASSERT_NEXT(a_ptr_hold, out_valid && out_stall, $stable(pointer_out), "pointer moved")

    // Only one item is in execution: an input transfer blocks the next cycle.
    `BBS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "taken while busy")

    // A new result appears only after a busy cycle.
    `BBS_ASSERT_SAME(a_rise_busy, $rose(out_valid), $past(in_stall), "result without compute")

    // Compare never reports equal and less at once.
    `BBS_ASSERT_SAME(a_flags_excl, out_valid, !(zero_out && carry_out), "both flags set")

endmodule

bind bidirectional_byte_stack_unit bbs_checker u_bbs_checker (.*);

// ----- bench/bidirectional_byte_stack_unit_tb.sv -----
`timescale 1ns / 1ps

module bidirectional_byte_stack_unit_tb;
    import bbs_pkg::*;

    // Command codes that the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int TOTAL_OPS = 1300;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int RX_HOLD_AT = 500;

    typedef struct {
        logic [2:0] cmd;
        logic       down;
        byte_t      val;
        int         gap;
        bit         drain_first;
    } stack_op_t;

    typedef struct {
        byte_t      rd;
        logic       zero;
        logic       carry;
        logic [7:0] ptr;
    } stack_reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = '0;
    logic       grow_down = 1'b0;
    logic [7:0] push_value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_value;
    logic       zero_out;
    logic       carry_out;
    logic [7:0] pointer_out;

    // Shadow copy of the stack state.
    byte_t model_mem [STACK_DEPTH];
    int    model_sp;
    logic  model_zero;
    logic  model_carry;

    stack_op_t    op_backlog[$];
    stack_reply_t predicted_replies[$];

    int sent_cnt = 0;
    int got_cnt = 0;
    int errors = 0;
    int idle_cycles = 0;

    // Sender state.
    int gap_left = 0;
    int tx_burst_left = 0;

    // Receiver state.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  rx_burst_left = 0;

    bidirectional_byte_stack_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .grow_down   (grow_down),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .zero_out    (zero_out),
        .carry_out   (carry_out),
        .pointer_out (pointer_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int wrap_addr(int p, int delta);
        return (p + delta + 2 * STACK_DEPTH) % STACK_DEPTH;
    endfunction

    // Apply one command to the shadow state and queue the reply it should produce.
    function automatic void compute_stack_reply(logic [2:0] cmd, logic down, byte_t val);
        stack_reply_t r;
        int back1;
        int back2;
        int fwd;
        byte_t a;
        byte_t b;
        back1 = wrap_addr(model_sp, down ? 1 : -1);
        back2 = wrap_addr(model_sp, down ? 2 : -2);
        fwd = wrap_addr(model_sp, down ? -1 : 1);
        r.rd = '0;
        case (cmd)
            CMD_PUSH:
            begin
                model_mem[model_sp] = val;
                model_sp = fwd;
            end
            CMD_POP:
            begin
                r.rd = model_mem[back1];
                model_mem[back1] = '0;
                model_sp = back1;
            end
            CMD_DUP:
            begin
                model_mem[model_sp] = model_mem[back1];
                model_sp = fwd;
            end
            CMD_DROP:
            begin
                model_mem[back1] = '0;
                model_sp = back1;
            end
            CMD_PEEK:
            begin
                r.rd = model_mem[back1];
            end
            CMD_COMPARE:
            begin
                a = model_mem[back1];
                b = model_mem[back2];
                model_zero = (a == b);
                model_carry = (a < b);
            end
            default:
            begin
            end
        endcase
        r.zero = model_zero;
        r.carry = model_carry;
        r.ptr = 8'(model_sp);
        predicted_replies.push_back(r);
    endfunction

    // Sender idle time, with occasional stretches of back-to-back transfers.
    function automatic int draw_tx_gap();
        if (tx_burst_left > 0)
        begin
            tx_burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            tx_burst_left = $urandom_range(15, 40);
        end
        return $urandom_range(0, 13);
    endfunction

    // Receiver wait per result, with occasional stretches of no stalling.
    function automatic int draw_rx_wait();
        if (rx_burst_left > 0)
        begin
            rx_burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            rx_burst_left = $urandom_range(15, 40);
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic void add_op(logic [2:0] cmd, logic down, byte_t val, bit drain);
        stack_op_t op;
        op.cmd = cmd;
        op.down = down;
        op.val = val;
        op.gap = draw_tx_gap();
        op.drain_first = drain;
        op_backlog.push_back(op);
    endfunction

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CMD_PUSH;
        if (r < 45) return CMD_POP;
        if (r < 55) return CMD_DUP;
        if (r < 65) return CMD_DROP;
        if (r < 75) return CMD_PEEK;
        if (r < 93) return CMD_COMPARE;
        if (r < 96) return CMD_SPARE_6;
        return CMD_SPARE_7;
    endfunction

    // Driver: presents queued commands, holds them while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        stack_op_t op;
        bit took;
        int in_flight;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            grow_down <= 1'b0;
            push_value <= '0;
            gap_left = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                compute_stack_reply(command, grow_down, push_value);
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_valid || took)
            begin
                in_flight = sent_cnt + int'(took) - got_cnt;
                if (op_backlog.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (op_backlog[0].drain_first && in_flight != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    op = op_backlog.pop_front();
                    in_valid <= 1'b1;
                    command <= op.cmd;
                    grow_down <= op.down;
                    push_value <= op.val;
                    gap_left = (op_backlog.size() != 0) ? op_backlog[0].gap : 0;
                end
            end
        end
    end

    // Monitor: takes results, checks them, and applies back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        stack_reply_t exp_r;
        int nxt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            nxt = stall_left;
            if (out_valid && !out_stall)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    errors++;
                end
                else
                begin
                    exp_r = predicted_replies.pop_front();
                    if (read_value !== exp_r.rd)
                    begin
                        $error("read_value: expected %0h, got %0h", exp_r.rd, read_value);
                        errors++;
                    end
                    if (zero_out !== exp_r.zero)
                    begin
                        $error("zero_out: expected %0b, got %0b", exp_r.zero, zero_out);
                        errors++;
                    end
                    if (carry_out !== exp_r.carry)
                    begin
                        $error("carry_out: expected %0b, got %0b", exp_r.carry, carry_out);
                        errors++;
                    end
                    if (pointer_out !== exp_r.ptr)
                    begin
                        $error("pointer_out: expected %0h, got %0h", exp_r.ptr, pointer_out);
                        errors++;
                    end
                end
                got_cnt <= got_cnt + 1;
                // One long hold-off so the block backs up into its input.
                if (got_cnt == RX_HOLD_AT - 1 && !hold_done)
                begin
                    hold_left = RX_HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                nxt = draw_rx_wait();
            end
            else if (out_valid && nxt > 0)
            begin
                nxt--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            stall_left = nxt;
            out_stall <= (nxt > 0) || (hold_left > 0);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic dir;
        logic [2:0] cmd;
        int seg_len;
        bit mixed;
        int total_ops;

        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            model_mem[i] = '0;
        end
        model_sp = 0;
        model_zero = 1'b0;
        model_carry = 1'b0;

        // Directed: empty-stack reads, byte extremes, all three compare outcomes,
        // spare codes, wrap below zero, and growth in both directions.
        add_op(CMD_PEEK, 1'b0, 8'h00, 1'b0);
        add_op(CMD_COMPARE, 1'b0, 8'hFF, 1'b0);
        add_op(CMD_PUSH, 1'b0, 8'h00, 1'b0);
        add_op(CMD_PUSH, 1'b0, 8'hFF, 1'b0);
        add_op(CMD_COMPARE, 1'b0, 8'h00, 1'b0);
        add_op(CMD_DUP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_COMPARE, 1'b0, 8'h00, 1'b0);
        add_op(CMD_POP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_DROP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_PUSH, 1'b0, 8'hA5, 1'b0);
        add_op(CMD_PUSH, 1'b0, 8'h5A, 1'b0);
        add_op(CMD_COMPARE, 1'b0, 8'h00, 1'b0);
        add_op(CMD_SPARE_6, 1'b1, 8'hFF, 1'b0);
        add_op(CMD_SPARE_7, 1'b0, 8'hFF, 1'b0);
        add_op(CMD_PEEK, 1'b0, 8'h00, 1'b1);
        add_op(CMD_POP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_POP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_POP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_POP, 1'b0, 8'h00, 1'b0);
        add_op(CMD_PUSH, 1'b1, 8'h3C, 1'b0);
        add_op(CMD_DUP, 1'b1, 8'h00, 1'b0);
        add_op(CMD_PEEK, 1'b1, 8'h00, 1'b0);
        add_op(CMD_COMPARE, 1'b1, 8'h00, 1'b0);
        add_op(CMD_POP, 1'b1, 8'h00, 1'b0);
        add_op(CMD_DROP, 1'b1, 8'h00, 1'b0);

        // Deep fill: mostly pushes and dups in one direction, then mostly pops and drops.
        dir = 1'($urandom_range(0, 1));
        for (int i = 0; i < 280; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_COMPARE : CMD_PEEK;
            end
            else
            begin
                cmd = ($urandom_range(0, 7) == 0) ? CMD_DUP : CMD_PUSH;
            end
            add_op(cmd, dir, 8'($urandom_range(0, 255)), i == 0);
        end
        for (int i = 0; i < 280; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_COMPARE : CMD_PEEK;
            end
            else
            begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_DROP : CMD_POP;
            end
            add_op(cmd, dir, 8'($urandom_range(0, 255)), 1'b0);
        end

        // Random segments, mostly in one direction; some mix directions per item.
        while (op_backlog.size() < TOTAL_OPS)
        begin
            seg_len = $urandom_range(10, 60);
            mixed = ($urandom_range(0, 9) == 0);
            dir = 1'($urandom_range(0, 1));
            for (int i = 0; i < seg_len && op_backlog.size() < TOTAL_OPS; i++)
            begin
                add_op(pick_cmd(), mixed ? 1'($urandom_range(0, 1)) : dir,
                       8'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
            end
        end
        total_ops = op_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt != total_ops)
        begin
            @(posedge clk);
        end
        while (got_cnt != sent_cnt)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (predicted_replies.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_replies.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bbs_pkg.sv
rtl/core/bbs_ram.sv
rtl/core/bidirectional_byte_stack_unit.sv
rtl/core/bbs_checker.sv
bench/bidirectional_byte_stack_unit_tb.sv
